@@ design/cnlv_pkg.sv @@
package cnlv_pkg;

   localparam int COUNT_WIDTH = 5;
   localparam int SUM_WIDTH = 4;
   localparam int CHAR_WIDTH = 8;
   localparam int STATUS_WIDTH = 3;
   localparam int CSR_INDEX_WIDTH = 1;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [SUM_WIDTH-1:0] digit_type;
   typedef logic [CHAR_WIDTH-1:0] char_type;
   typedef logic [STATUS_WIDTH-1:0] status_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam count_type COUNT_MAX = 5'd31;
   localparam count_type MIN_LENGTH_RESET = 5'd13;
   localparam count_type MAX_LENGTH_RESET = 5'd16;

   localparam csr_index_type CSR_MIN_LENGTH = 1'd0;
   localparam csr_index_type CSR_MAX_LENGTH = 1'd1;

   localparam status_type STATUS_VALID = 3'd0;
   localparam status_type STATUS_BAD_LENGTH = 3'd1;
   localparam status_type STATUS_BAD_TYPE = 3'd2;
   localparam status_type STATUS_NON_DIGIT = 3'd3;
   localparam status_type STATUS_LUHN_FAIL = 3'd4;

   localparam char_type CHAR_0 = 8'h30;
   localparam char_type CHAR_3 = 8'h33;
   localparam char_type CHAR_4 = 8'h34;
   localparam char_type CHAR_5 = 8'h35;
   localparam char_type CHAR_6 = 8'h36;
   localparam char_type CHAR_7 = 8'h37;
   localparam char_type CHAR_9 = 8'h39;

   // Luhn doubling of one digit: 2d, less 9 when that exceeds 9.
   function automatic digit_type digit_double(input digit_type d);
      logic [SUM_WIDTH:0] t;
      t = {d, 1'b0};
      if (t > 5'd9) begin
         t = t - 5'd9;
      end
      return t[SUM_WIDTH-1:0];
   endfunction

   function automatic digit_type add_mod10(input digit_type a, input digit_type b);
      logic [SUM_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 5'd10) begin
         s = s - 5'd10;
      end
      return s[SUM_WIDTH-1:0];
   endfunction

endpackage

@@ design/card_number_luhn_validator.sv @@
// Card number checker: characters arrive one item per cycle when ready, leftmost first, and
// the item flagged as last produces one status (valid, bad length, bad prefix, non-digit, or
// Luhn failure, checked in that order). The block sustains one character per clock cycle
// unless a last character waits on a stalled result side; each item passes an
// input register, then the running-sum update and final checks, then the result register.
// Lengths above 31 are judged as 31. The user must write the length bounds through the csr
// port only while no number is in flight; the block itself does not enforce this.
module card_number_luhn_validator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  cnlv_pkg::char_type            req_char_code,
   input  logic                          req_is_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output cnlv_pkg::status_type          rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  cnlv_pkg::csr_index_type       csr_index,
   input  cnlv_pkg::count_type           csr_wdata
);

   logic                   s1_valid_ff, s1_valid_in;
   cnlv_pkg::char_type     s1_char_ff;
   logic                   s1_last_ff;
   logic                   out_valid_ff, out_valid_in;
   cnlv_pkg::status_type   out_status_ff, out_status_in;

   cnlv_pkg::count_type    min_length_ff, max_length_ff;
   cnlv_pkg::count_type    count_ff, count_in;
   cnlv_pkg::digit_type    sum_even_ff, sum_even_in;
   cnlv_pkg::digit_type    sum_odd_ff, sum_odd_in;
   cnlv_pkg::char_type     first_ff, first_in;
   cnlv_pkg::char_type     second_ff, second_in;
   logic                   bad_ff, bad_in;

   logic                   out_free;
   logic                   s1_move;
   logic                   is_digit;
   cnlv_pkg::digit_type    digit;
   cnlv_pkg::digit_type    digit_dbl;
   cnlv_pkg::digit_type    luhn;
   logic                   prefix_ok;

   assign out_free = !out_valid_ff || rsp_ready;
   assign s1_move = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ready = !s1_valid_ff || s1_move;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !s1_move);

   assign rsp_valid = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      is_digit = s1_char_ff inside {[cnlv_pkg::CHAR_0:cnlv_pkg::CHAR_9]};
      digit = s1_char_ff[cnlv_pkg::SUM_WIDTH-1:0];
      digit_dbl = cnlv_pkg::digit_double(digit);

      first_in = (count_ff == 5'd0) ? s1_char_ff : first_ff;
      second_in = (count_ff == 5'd1) ? s1_char_ff : second_ff;
      bad_in = bad_ff || !is_digit;
      sum_even_in = sum_even_ff;
      sum_odd_in = sum_odd_ff;
      if (is_digit) begin
         if (!count_ff[0]) begin
            sum_even_in = cnlv_pkg::add_mod10(sum_even_ff, digit_dbl);
            sum_odd_in = cnlv_pkg::add_mod10(sum_odd_ff, digit);
         end else begin
            sum_even_in = cnlv_pkg::add_mod10(sum_even_ff, digit);
            sum_odd_in = cnlv_pkg::add_mod10(sum_odd_ff, digit_dbl);
         end
      end
      count_in = (count_ff != cnlv_pkg::COUNT_MAX) ? count_ff + 5'd1 : cnlv_pkg::COUNT_MAX;

      luhn = count_in[0] ? sum_odd_in : sum_even_in;
      prefix_ok = (first_in inside {cnlv_pkg::CHAR_4, cnlv_pkg::CHAR_5, cnlv_pkg::CHAR_6})
                  || (first_in == cnlv_pkg::CHAR_3 && second_in == cnlv_pkg::CHAR_7);

      if (count_in < min_length_ff || count_in > max_length_ff) begin
         out_status_in = cnlv_pkg::STATUS_BAD_LENGTH;
      end else if (!prefix_ok) begin
         out_status_in = cnlv_pkg::STATUS_BAD_TYPE;
      end else if (bad_in) begin
         out_status_in = cnlv_pkg::STATUS_NON_DIGIT;
      end else if (luhn != 4'd0) begin
         out_status_in = cnlv_pkg::STATUS_LUHN_FAIL;
      end else begin
         out_status_in = cnlv_pkg::STATUS_VALID;
      end

      out_valid_in = (s1_move && s1_last_ff) || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         min_length_ff <= cnlv_pkg::MIN_LENGTH_RESET;
         max_length_ff <= cnlv_pkg::MAX_LENGTH_RESET;
         count_ff <= '0;
         sum_even_ff <= '0;
         sum_odd_ff <= '0;
         first_ff <= '0;
         second_ff <= '0;
         bad_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               cnlv_pkg::CSR_MIN_LENGTH: min_length_ff <= csr_wdata;
               cnlv_pkg::CSR_MAX_LENGTH: max_length_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (s1_move) begin
            if (s1_last_ff) begin
               count_ff <= '0;
               sum_even_ff <= '0;
               sum_odd_ff <= '0;
               first_ff <= '0;
               second_ff <= '0;
               bad_ff <= 1'b0;
            end else begin
               count_ff <= count_in;
               sum_even_ff <= sum_even_in;
               sum_odd_ff <= sum_odd_in;
               first_ff <= first_in;
               second_ff <= second_in;
               bad_ff <= bad_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_char_ff <= req_char_code;
         s1_last_ff <= req_is_last;
      end
      if (s1_move && s1_last_ff) begin
         out_status_ff <= out_status_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      s1_move && s1_last_ff |=> count_ff == 5'd0 && !bad_ff && first_ff == 8'd0)
      else $error("Number state not cleared after the last character.");

   assert property (@(posedge clock) disable iff (reset)
      sum_even_ff < 4'd10 && sum_odd_ff < 4'd10)
      else $error("Running Luhn sum left the mod-10 range.");

   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_char_ff) && $stable(s1_last_ff))
      else $error("Held character lost from the input register.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= cnlv_pkg::STATUS_LUHN_FAIL)
      else $error("Status code out of range.");

endmodule
